FILE: design/hsw_pkg.sv
// hsw_pkg: shared types and constants of the heightmap steepness window
// used by hsw_ctrl, hsw_datapath and the top level
`timescale 1ns / 1ps

package hsw_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_STEEP_COEF   = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration reset values
	localparam logic [10:0] WIDTH_RST  = 11'd1024;
	localparam logic [15:0] HEIGHT_RST = 16'd1024;
	localparam logic [11:0] COEF_RST   = 12'd256;

	// result slots in emission order
	localparam logic [1:0] SLOT_DIAG = 2'd0;  // (r-1, c-1), five-way average
	localparam logic [1:0] SLOT_UP   = 2'd1;  // (r-1, c) on the last column
	localparam logic [1:0] SLOT_LEFT = 2'd2;  // (r, c-1) on the last row
	localparam logic [1:0] SLOT_SELF = 2'd3;  // (r, c) on the final pixel

	// saturation limits (255 times the divisor) and reciprocals
	localparam logic [13:0] SAT_DIV5 = 14'd1275;
	localparam logic [13:0] SAT_DIV3 = 14'd765;
	localparam logic [13:0] SAT_DIV2 = 14'd510;
	localparam logic [10:0] RECIP5   = 11'd1639;  // 2^13 / 5, exact below 2730
	localparam logic [10:0] RECIP3   = 11'd683;   // 2^11 / 3, exact below 2048

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_FIN,
		ST_OUT,
		ST_UPD
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // input transfer: latch sample, counters, row store read
		logic mul;      // pick next pending slot, register operands and product
		logic fin;      // scale, divide and clamp into the output register
		logic clear;    // output transfer: drop the delivered slot
		logic update;   // write row store, shift window, advance counters
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic pend_any;  // results still to emit for the current pixel
	} ctrl_sts_t;

endpackage

FILE: design/hsw_ctrl.sv
// hsw_ctrl: sequencer of the steepness window
// depends on hsw_pkg for state and command types
`timescale 1ns / 1ps

module hsw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output hsw_pkg::ctrl_cmd_t cmd,
	input  hsw_pkg::ctrl_sts_t sts
);
	import hsw_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_SEL;
			end
			ST_SEL: begin
				state_nxt = sts.pend_any ? ST_FIN : ST_UPD;
			end
			ST_FIN: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (m_tready) state_nxt = ST_SEL;
			end
			ST_UPD: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs and commands
	always_comb begin
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_SEL: begin
				cmd.mul = sts.pend_any;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
			end
			ST_OUT: begin
				m_tvalid  = 1'b1;
				cmd.clear = m_tready;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: design/hsw_datapath.sv
// hsw_datapath: config registers, row store, window, counters and the
// shared multiply / divide unit; depends on hsw_pkg
`timescale 1ns / 1ps

module hsw_datapath #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hsw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hsw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [7:0]                      height,
	input  hsw_pkg::ctrl_cmd_t              cmd,
	output hsw_pkg::ctrl_sts_t              sts,
	output logic [15:0]                     out_row,
	output logic [9:0]                      out_column,
	output logic [7:0]                      out_steepness,
	output logic                            out_last
);
	import hsw_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

	// configuration
	logic [10:0] width_q;
	logic [15:0] height_cfg_q;
	logic [11:0] coef_q;

	// window and counters
	logic [7:0]    mem [MAX_WIDTH];
	logic [7:0]    up_rd_q;
	logic [7:0]    ul_q;
	logic [7:0]    lf_q;
	logic [7:0]    h_q;
	logic [CW-1:0] col_cnt_q;
	logic [15:0]   row_cnt_q;
	logic [CW-1:0] c_q;
	logic [15:0]   r_q;
	logic          lastc_q;
	logic          lastr_q;
	logic [3:0]    pend_q;

	// arithmetic stage
	logic [1:0]    slot_s1;
	logic [7:0]    self_s1;
	logic [21:0]   prod_s1;
	logic [15:0]   row_s1;
	logic [CW-1:0] col_s1;
	logic          last_s1;

	// configuration writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= WIDTH_RST;
			height_cfg_q <= HEIGHT_RST;
			coef_q       <= COEF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q      <= cfg_wdata[10:0];
				CFG_IMAGE_HEIGHT: height_cfg_q <= cfg_wdata[15:0];
				CFG_STEEP_COEF:   coef_q       <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	// effective size and clamped position of the incoming pixel
	logic [WW-1:0] w_ext;
	logic [WW-1:0] w_eff;
	logic [CW-1:0] w_m1;
	logic [15:0]   h_m1;
	logic [CW-1:0] c_cur;
	logic [15:0]   r_cur;
	logic          lastc_cur;
	logic          lastr_cur;

	always_comb begin
		w_ext = WW'(width_q);
		if (w_ext == '0) begin
			w_eff = WW'(1);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		w_m1      = CW'(w_eff - WW'(1));
		h_m1      = (height_cfg_q == '0) ? 16'd0 : height_cfg_q - 16'd1;
		c_cur     = (col_cnt_q > w_m1) ? w_m1 : col_cnt_q;
		r_cur     = (row_cnt_q > h_m1) ? h_m1 : row_cnt_q;
		lastc_cur = (c_cur == w_m1);
		lastr_cur = (r_cur == h_m1);
	end

	// row store read at the input transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			up_rd_q <= mem[c_cur];
		end
	end

	// row store write once the pixel is done
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[c_q] <= h_q;
		end
	end

	// input sample and position of the current pixel
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			h_q     <= height;
			c_q     <= c_cur;
			r_q     <= r_cur;
			lastc_q <= lastc_cur;
			lastr_q <= lastr_cur;
		end
	end

	// pending result slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd.capture) begin
			pend_q[SLOT_DIAG] <= (r_cur != '0) && (c_cur != '0);
			pend_q[SLOT_UP]   <= (r_cur != '0) && lastc_cur;
			pend_q[SLOT_LEFT] <= lastr_cur && (c_cur != '0);
			pend_q[SLOT_SELF] <= lastr_cur && lastc_cur;
		end else if (cmd.clear) begin
			pend_q[slot_s1] <= 1'b0;
		end
	end

	assign sts.pend_any = (pend_q != '0);

	// window registers and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_q      <= '0;
			lf_q      <= '0;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (cmd.update) begin
			ul_q <= up_rd_q;
			lf_q <= h_q;
			if (lastc_q) begin
				col_cnt_q <= '0;
				row_cnt_q <= lastr_q ? 16'd0 : r_q + 16'd1;
			end else begin
				col_cnt_q <= c_q + CW'(1);
				row_cnt_q <= r_q;
			end
		end
	end

	// lowest pending slot and its operands
	logic [3:0] low_bit;
	logic [1:0] slot_nxt;
	logic [7:0] d_ul_up;
	logic [7:0] d_ul_lf;
	logic [7:0] d_ul_h;
	logic [7:0] d_up_h;
	logic [7:0] d_lf_h;
	logic [7:0] self_nxt;
	logic [9:0] sum_nxt;
	logic [15:0] row_nxt;
	logic [CW-1:0] col_nxt;

	always_comb begin
		low_bit = pend_q & (~pend_q + 4'd1);
		if (pend_q[SLOT_DIAG]) begin
			slot_nxt = SLOT_DIAG;
		end else if (pend_q[SLOT_UP]) begin
			slot_nxt = SLOT_UP;
		end else if (pend_q[SLOT_LEFT]) begin
			slot_nxt = SLOT_LEFT;
		end else begin
			slot_nxt = SLOT_SELF;
		end
		d_ul_up = (ul_q > up_rd_q) ? ul_q - up_rd_q : up_rd_q - ul_q;
		d_ul_lf = (ul_q > lf_q) ? ul_q - lf_q : lf_q - ul_q;
		d_ul_h  = (ul_q > h_q) ? ul_q - h_q : h_q - ul_q;
		d_up_h  = (up_rd_q > h_q) ? up_rd_q - h_q : h_q - up_rd_q;
		d_lf_h  = (lf_q > h_q) ? lf_q - h_q : h_q - lf_q;
		case (slot_nxt)
			SLOT_DIAG: begin
				self_nxt = ul_q;
				sum_nxt  = 10'(d_ul_up) + 10'(d_ul_lf) + 10'(d_ul_h);
				row_nxt  = r_q - 16'd1;
				col_nxt  = c_q - CW'(1);
			end
			SLOT_UP: begin
				self_nxt = up_rd_q;
				sum_nxt  = 10'(d_up_h);
				row_nxt  = r_q - 16'd1;
				col_nxt  = c_q;
			end
			SLOT_LEFT: begin
				self_nxt = lf_q;
				sum_nxt  = 10'(d_lf_h);
				row_nxt  = r_q;
				col_nxt  = c_q - CW'(1);
			end
			default: begin
				self_nxt = h_q;
				sum_nxt  = 10'd0;
				row_nxt  = r_q;
				col_nxt  = c_q;
			end
		endcase
	end

	// weighted difference product
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			slot_s1 <= slot_nxt;
			self_s1 <= self_nxt;
			prod_s1 <= 22'(coef_q * sum_nxt);
			row_s1  <= row_nxt;
			col_s1  <= col_nxt;
			last_s1 <= ((pend_q & ~low_bit) == '0);
		end
	end

	// scale, divide by the neighbour count and clamp
	logic [21:0] num;
	logic [13:0] quo;
	logic [21:0] recip_prod;
	logic [7:0]  steep_nxt;

	always_comb begin
		num        = {6'd0, self_s1, 8'd0} + prod_s1;
		quo        = num[21:8];
		recip_prod = '0;
		case (slot_s1)
			SLOT_DIAG: begin
				recip_prod = 22'(quo[10:0] * RECIP5);
				steep_nxt  = (quo >= SAT_DIV5) ? 8'd255 : recip_prod[20:13];
			end
			SLOT_UP, SLOT_LEFT: begin
				recip_prod = 22'(quo[10:0] * RECIP3);
				steep_nxt  = (quo >= SAT_DIV3) ? 8'd255 : recip_prod[18:11];
			end
			default: begin
				steep_nxt = (quo >= SAT_DIV2) ? 8'd255 : quo[8:1];
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_row       <= row_s1;
			out_column    <= 10'(col_s1);
			out_steepness <= steep_nxt;
			out_last      <= last_s1;
		end
	end

endmodule

FILE: design/heightmap_steepness_window.sv
// heightmap_steepness_window: top level, joins sequencer and datapath
// depends on hsw_pkg, hsw_ctrl and hsw_datapath
`timescale 1ns / 1ps

// Height samples enter in raster order, one per transfer; results trail the
// input by one row and one column, with the last column and the last row
// adding their edge results, each tagged with its row and column, and tlast
// marks the final result caused by an input. One multiply / divide unit serves
// the results one after the other, each waiting for the sink if it stalls, and
// no new pixel is taken before all results of the last one are delivered; a
// pixel causes 0 to 4 results, typically one. The line buffer needs no clearing
// pass after reset; the block accepts a pixel in the first cycle out of reset.
// Configuration must be written only while the block is idle; the block does not enforce it.

module heightmap_steepness_window #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [hsw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// height samples
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] height
	// steepness results
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [39:0]                    m_tdata,   // [15:0] row, [25:16] column,
	                                                  // [33:26] steepness, zero above
	output logic                           m_tlast    // last_in_run
);
	import hsw_pkg::*;

	ctrl_cmd_t   cmd;
	ctrl_sts_t   sts;
	logic [15:0] out_row;
	logic [9:0]  out_column;
	logic [7:0]  out_steepness;

	// sequencer
	hsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// window and arithmetic
	hsw_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.height        (s_tdata),
		.cmd           (cmd),
		.sts           (sts),
		.out_row       (out_row),
		.out_column    (out_column),
		.out_steepness (out_steepness),
		.out_last      (m_tlast)
	);

	// result packing
	assign m_tdata = {6'd0, out_steepness, out_column, out_row};

endmodule

FILE: design/hsw_checker.sv
// hsw_checker: port-level checks of heightmap_steepness_window
// bound to the top level; needs no package
`timescale 1ns / 1ps

module hsw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// one pixel at a time: no input while a result is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is offered");

	// an accepted pixel closes the input until its work is done
	a_in_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid)
		else $error("input or output open right after an input transfer");

	// each result needs a fresh pass of the arithmetic unit
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("results offered back to back");

endmodule

bind heightmap_steepness_window hsw_checker u_hsw_checker (.*);
